@@ hw/rtl/rv32i_instruction_decoder_macros.svh @@
// Assertion macros used by the decoder checker.
// Included by hw/rtl/rvid_checker.sv; needs no other file.
`ifndef RV32I_INSTRUCTION_DECODER_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_MACROS_SVH

// concurrent check, off while reset is high
`define RVID_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("rvid check failed");

// concurrent check that also runs through reset
`define RVID_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("rvid reset check failed");

`endif

@@ hw/rtl/rvid_pkg.sv @@
// Mnemonic codes, opcodes and widths of the RV32I decoder.
// No dependencies; used by the decoder and its checker.
package rvid_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned ImmWidth  = 21;
  localparam int unsigned CodeWidth = 6;
  localparam int unsigned RegWidth  = 5;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef enum logic [CodeWidth-1:0] {
    MN_UNKNOWN = 6'd0,
    MN_ADD   = 6'd1,  MN_SUB   = 6'd2,  MN_SLL   = 6'd3,  MN_SLT   = 6'd4,
    MN_SLTU  = 6'd5,  MN_XOR   = 6'd6,  MN_SRL   = 6'd7,  MN_SRA   = 6'd8,
    MN_OR    = 6'd9,  MN_AND   = 6'd10,
    MN_ADDI  = 6'd11, MN_SLLI  = 6'd12, MN_SLTI  = 6'd13, MN_SLTIU = 6'd14,
    MN_XORI  = 6'd15, MN_SRLI  = 6'd16, MN_SRAI  = 6'd17, MN_ORI   = 6'd18,
    MN_ANDI  = 6'd19,
    MN_LB    = 6'd20, MN_LH    = 6'd21, MN_LW    = 6'd22, MN_LBU   = 6'd23,
    MN_LHU   = 6'd24,
    MN_SB    = 6'd25, MN_SH    = 6'd26, MN_SW    = 6'd27,
    MN_BEQ   = 6'd28, MN_BNE   = 6'd29, MN_BLT   = 6'd30, MN_BGE   = 6'd31,
    MN_BLTU  = 6'd32, MN_BGEU  = 6'd33,
    MN_LUI   = 6'd34, MN_AUIPC = 6'd35, MN_JAL   = 6'd36, MN_JALR  = 6'd37,
    MN_ECALL = 6'd38
  } mnemonic_t;

endpackage

@@ hw/rtl/rv32i_instruction_decoder.sv @@
// RV32I instruction decoder: instruction word in, decoded record out.
// Depends on rvid_pkg.
//
// Usage:
//   Input channel  instr_valid / instr_stall carries instr_word.
//   Output channel dec_valid / dec_stall carries mnemonic, dest_reg,
//   src1_reg, src2_reg and immediate. A beat moves at a rising edge with
//   valid high and stall low.
//   Every word yields exactly one record; unknown words give mnemonic 0.
//   Path: a word passes the input register, then decode into the result
//   register, from which the receiver takes the record.
//   Throughput: one word per cycle while dec_stall is low; the decode is a single pass of
//   opcode/funct selection between the two registers.
//   Reset (rst, synchronous) empties both registers; beats held in them are
//   dropped, and no beat is produced by it.
//   When the receiver stalls, the result register holds; the input
//   register still takes one more beat, and instr_stall rises only when
//   both registers are full.
module rv32i_instruction_decoder
  import rvid_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       instr_valid,
  output logic                       instr_stall,
  input  logic [WordWidth-1:0]       instr_word,
  output logic                       dec_valid,
  input  logic                       dec_stall,
  output logic [CodeWidth-1:0]       mnemonic,
  output logic [RegWidth-1:0]        dest_reg,
  output logic [RegWidth-1:0]        src1_reg,
  output logic [RegWidth-1:0]        src2_reg,
  output logic signed [ImmWidth-1:0] immediate
);

  logic                 word_valid;
  logic [WordWidth-1:0] word;
  logic                 adv_out;
  logic                 adv_in;

  mnemonic_t                code_next;
  logic signed [ImmWidth-1:0] imm_next;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic signed [ImmWidth-1:0] imm_i, imm_sh, imm_s, imm_b, imm_u, imm_j;

  assign adv_out     = !dec_valid || !dec_stall;
  assign adv_in      = !word_valid || adv_out;
  assign instr_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (adv_in) begin
      word_valid <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && instr_valid) begin
      word <= instr_word;
    end
  end

  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign f7  = word[31:25];

  assign imm_i  = {{9{word[31]}}, word[31:20]};
  assign imm_sh = {16'd0, word[24:20]};
  assign imm_s  = {{9{word[31]}}, word[31:25], word[11:7]};
  assign imm_b  = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u  = {word[31], word[31:12]};
  assign imm_j  = {word[31], word[19:12], word[20], word[30:21], 1'b0};

  always_comb begin
    code_next = MN_UNKNOWN;
    imm_next  = '0;
    case (opc)
      OPC_OP: begin
        if (f7 == F7_BASE || f7 == F7_ALT) begin
          case (f3)
            3'd0:    code_next = (f7 == F7_ALT) ? MN_SUB : MN_ADD;
            3'd1:    code_next = MN_SLL;
            3'd2:    code_next = MN_SLT;
            3'd3:    code_next = MN_SLTU;
            3'd4:    code_next = MN_XOR;
            3'd5:    code_next = (f7 == F7_ALT) ? MN_SRA : MN_SRL;
            3'd6:    code_next = MN_OR;
            default: code_next = MN_AND;
          endcase
        end
      end
      OPC_OP_IMM: begin
        imm_next = imm_i;
        case (f3)
          3'd0: code_next = MN_ADDI;
          3'd1: begin
            code_next = MN_SLLI;
            imm_next  = imm_sh;
          end
          3'd2: code_next = MN_SLTI;
          3'd3: code_next = MN_SLTIU;
          3'd4: code_next = MN_XORI;
          3'd5: begin
            code_next = word[30] ? MN_SRAI : MN_SRLI;
            imm_next  = imm_sh;
          end
          3'd6:    code_next = MN_ORI;
          default: code_next = MN_ANDI;
        endcase
      end
      OPC_LOAD: begin
        imm_next = imm_i;
        case (f3)
          3'd0: code_next = MN_LB;
          3'd1: code_next = MN_LH;
          3'd2: code_next = MN_LW;
          3'd4: code_next = MN_LBU;
          3'd5: code_next = MN_LHU;
          default: begin
            code_next = MN_UNKNOWN;
            imm_next  = '0;
          end
        endcase
      end
      OPC_JALR: begin
        code_next = MN_JALR;
        imm_next  = imm_i;
      end
      OPC_SYSTEM: code_next = MN_ECALL;
      OPC_STORE: begin
        imm_next = imm_s;
        case (f3)
          3'd0: code_next = MN_SB;
          3'd1: code_next = MN_SH;
          3'd2: code_next = MN_SW;
          default: begin
            code_next = MN_UNKNOWN;
            imm_next  = '0;
          end
        endcase
      end
      OPC_BRANCH: begin
        imm_next = imm_b;
        case (f3)
          3'd0: code_next = MN_BEQ;
          3'd1: code_next = MN_BNE;
          3'd4: code_next = MN_BLT;
          3'd5: code_next = MN_BGE;
          3'd6: code_next = MN_BLTU;
          3'd7: code_next = MN_BGEU;
          default: begin
            code_next = MN_UNKNOWN;
            imm_next  = '0;
          end
        endcase
      end
      OPC_LUI: begin
        code_next = MN_LUI;
        imm_next  = imm_u;
      end
      OPC_AUIPC: begin
        code_next = MN_AUIPC;
        imm_next  = imm_u;
      end
      OPC_JAL: begin
        code_next = MN_JAL;
        imm_next  = imm_j;
      end
      default: begin
        code_next = MN_UNKNOWN;
        imm_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (adv_out) begin
      dec_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && word_valid) begin
      mnemonic  <= code_next;
      dest_reg  <= word[11:7];
      src1_reg  <= word[19:15];
      src2_reg  <= word[24:20];
      immediate <= imm_next;
    end
  end

endmodule

@@ hw/rtl/rvid_checker.sv @@
// Port-level checks for the RV32I decoder, bound to its top level.
// Depends on rvid_pkg and rv32i_instruction_decoder_macros.svh.
`include "rv32i_instruction_decoder_macros.svh"

module rvid_checker
  import rvid_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       instr_valid,
  input logic                       instr_stall,
  input logic [WordWidth-1:0]       instr_word,
  input logic                       dec_valid,
  input logic                       dec_stall,
  input logic [CodeWidth-1:0]       mnemonic,
  input logic [RegWidth-1:0]        dest_reg,
  input logic [RegWidth-1:0]        src1_reg,
  input logic [RegWidth-1:0]        src2_reg,
  input logic signed [ImmWidth-1:0] immediate
);

  logic no_imm;
  logic even_imm;
  logic in_hold;

  assign no_imm = mnemonic == MN_UNKNOWN || mnemonic == MN_ECALL ||
                  (mnemonic >= MN_ADD && mnemonic <= MN_AND);
  assign even_imm = mnemonic == MN_JAL ||
                    (mnemonic >= MN_BEQ && mnemonic <= MN_BGEU);
  assign in_hold = instr_valid && instr_stall;

  `RVID_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !dec_valid)
  `RVID_ASSERT(a_hold_when_stalled, clk, rst,
    dec_valid && dec_stall |=> dec_valid && $stable(mnemonic) && $stable(immediate))
  `RVID_ASSERT(a_no_imm_zero, clk, rst, dec_valid && no_imm |-> immediate == '0)
  `RVID_ASSERT(a_offset_even, clk, rst, dec_valid && even_imm |-> !immediate[0])
  `RVID_ASSERT(a_input_held, clk, rst, in_hold |=> instr_valid && $stable(instr_word))

endmodule

bind rv32i_instruction_decoder rvid_checker u_rvid_checker (.*);
